>>> sv/a85_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the line-wrapped ASCII85 encoder.
// No dependencies; every other file of the block uses this package.
package a85_pkg;

   localparam int MAX_LINE_WIDTH_DEF = 1020;
   localparam int LINE_WIDTH_W       = 10;
   localparam int LINE_WIDTH_RESET   = 75;
   localparam int MIN_WIDTH          = 5;
   // Largest rounded width that a 10-bit line width register can ask for.
   localparam int WIDTH_CEIL_MAX     = 1025;

   localparam int JOB_DEPTH   = 2;
   localparam int RSP_DEPTH   = 2;
   localparam int NUM_DIGITS  = 5;
   localparam int NIBBLES     = 8;
   localparam int RADIX_N     = 85;

   localparam logic [7:0] RADIX  = 8'(RADIX_N);
   // 205 / 1024 is close enough to 1/5 to divide any 10-bit value exactly.
   localparam logic [7:0] RECIP5 = 8'd205;

   localparam logic [6:0] DIGIT_BASE = 7'd33;
   localparam logic [6:0] CH_Z       = 7'd122;
   localparam logic [6:0] CH_NL      = 7'd10;
   localparam logic [6:0] CH_TILDE   = 7'd126;
   localparam logic [6:0] CH_GT      = 7'd62;

   typedef enum logic {
      REG_LINE_WIDTH     = 1'b0,
      REG_PUT_END_MARKER = 1'b1
   } csr_index_type;

   typedef logic [NUM_DIGITS-1:0][6:0] digits_type;
   typedef logic [RADIX_N-1:0][10:0]   mul16_tab_type;

   typedef struct packed {
      logic [31:0] word;
      logic        is_zero;
      logic        is_last;
   } job_type;

   typedef struct packed {
      digits_type digits;
      logic       is_zero;
      logic       is_last;
   } digit_job_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       last_char;
   } rsp_type;

   function automatic int eff_cap(int max_width);
      int c;
      c = (max_width / 5) * 5;
      if (c < MIN_WIDTH) c = MIN_WIDTH;
      return c;
   endfunction

   function automatic int col_bits(int max_width);
      int m;
      m = eff_cap(max_width);
      if (m > WIDTH_CEIL_MAX) m = WIDTH_CEIL_MAX;
      return $clog2(m + 1);
   endfunction

   // Entry d holds {16*d / 85, 16*d % 85}, built by stepping d upward.
   function automatic mul16_tab_type build_mul16();
      mul16_tab_type t;
      int q;
      int r;
      q = 0;
      r = 0;
      for (int d = 0; d < RADIX_N; d++) begin
         t[d] = {4'(q), 7'(r)};
         r = r + 16;
         if (r >= RADIX_N) begin
            r = r - RADIX_N;
            q = q + 1;
         end
      end
      return t;
   endfunction

   localparam mul16_tab_type MUL16_TAB = build_mul16();

   // Multiplies the base-85 number by 16 and adds one nibble, carrying from
   // the least significant digit upward.
   function automatic digits_type radix_step(digits_type d, logic [3:0] nib);
      digits_type r;
      logic [3:0] c;
      logic [10:0] e;
      logic [7:0] s;
      c = nib;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         e = MUL16_TAB[d[i]];
         s = {1'b0, e[6:0]} + {4'b0000, c};
         if (s >= RADIX) begin
            r[i] = 7'(s - RADIX);
            c    = e[10:7] + 4'd1;
         end else begin
            r[i] = s[6:0];
            c    = e[10:7];
         end
      end
      return r;
   endfunction

endpackage

>>> sv/a85_fifo.sv
`timescale 1ns / 1ps
// Small register queue with push/full and pop/empty sides.
// Depends on a85_pkg for default sizes.
module a85_fifo #(
   parameter int WIDTH = 34,
   parameter int DEPTH = a85_pkg::JOB_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/a85_front.sv
`timescale 1ns / 1ps
// Front end: packs bytes big-endian into words and classifies each finished word.
// Depends on a85_pkg for the job type.
module a85_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   output logic              q_push,
   output a85_pkg::job_type  q_job,
   input  logic              q_full
);

   logic [31:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] word;
   logic [4:0]  shift;
   logic        accept;
   logic        complete;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   // The byte lands in slot cnt from the top; lower slots stay zero.
   assign shift    = {~cnt_ff, 3'b000};
   assign word     = acc_ff | ({24'd0, req_data_byte} << shift);
   assign complete = (cnt_ff == 2'd3) || req_last_byte;

   always_comb begin
      q_push        = accept && complete;
      q_job.word    = word;
      q_job.is_zero = (word == 32'd0);
      q_job.is_last = req_last_byte;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      if (accept) begin
         acc_in = complete ? 32'd0 : word;
         cnt_in = complete ? 2'd0 : cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> sv/a85_conv.sv
`timescale 1ns / 1ps
// Back end, first part: converts a 32-bit word to five base-85 digits, one nibble a cycle, the last waiting for room.
// Depends on a85_pkg for the radix step and the job types.
module a85_conv (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   output logic                    q_pop,
   input  a85_pkg::job_type        q_job,
   output logic                    res_valid,
   output a85_pkg::digit_job_type  res_job,
   input  logic                    res_ready
);

   localparam int NIB_W = $clog2(a85_pkg::NIBBLES);
   localparam logic [NIB_W-1:0] NIB_LAST = NIB_W'(a85_pkg::NIBBLES - 1);

   logic                   busy_ff, busy_in;
   logic [NIB_W-1:0]       nib_ff, nib_in;
   logic                   res_valid_ff, res_valid_in;
   logic [31:0]            word_ff;
   a85_pkg::digits_type    dig_ff;
   logic                   zero_ff;
   logic                   last_ff;
   a85_pkg::digit_job_type res_ff;
   a85_pkg::digits_type    dig_step;
   logic                   res_free;
   logic                   finishing;
   logic                   step;
   logic                   start;

   assign dig_step  = a85_pkg::radix_step(dig_ff, word_ff[31:28]);
   assign res_free  = !res_valid_ff || res_ready;
   // The last nibble can only be taken when the result register has room.
   assign finishing = busy_ff && (nib_ff == NIB_LAST) && res_free;
   assign step      = busy_ff && ((nib_ff != NIB_LAST) || res_free);
   assign start     = !q_empty && (!busy_ff || finishing);
   assign q_pop     = start;
   assign res_valid = res_valid_ff;
   assign res_job   = res_ff;

   always_comb begin
      busy_in      = start || (busy_ff && !finishing);
      nib_in       = nib_ff;
      if (start) begin
         nib_in = '0;
      end else if (step) begin
         nib_in = nib_ff + 1'b1;
      end
      res_valid_in = finishing || (res_valid_ff && !res_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         nib_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         nib_ff       <= nib_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         word_ff <= q_job.word;
         dig_ff  <= '0;
         zero_ff <= q_job.is_zero;
         last_ff <= q_job.is_last;
      end else if (step) begin
         word_ff <= {word_ff[27:0], 4'h0};
         dig_ff  <= dig_step;
      end
      if (finishing) begin
         res_ff.digits  <= dig_step;
         res_ff.is_zero <= zero_ff;
         res_ff.is_last <= last_ff;
      end
   end

endmodule

>>> sv/a85_emit.sv
`timescale 1ns / 1ps
// Back end, second part: sends digits, line breaks and the end marker one character a cycle while the output has room.
// Depends on a85_pkg for character codes and job types.
module a85_emit #(
   parameter int MAX_LINE_WIDTH = a85_pkg::MAX_LINE_WIDTH_DEF,
   localparam int COL_W = a85_pkg::col_bits(MAX_LINE_WIDTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  a85_pkg::digit_job_type job,
   output logic                   job_ready,
   input  logic [COL_W-1:0]       eff,
   input  logic                   put_end_marker,
   output logic                   out_push,
   output a85_pkg::rsp_type       out_data,
   input  logic                   out_full
);

   localparam int LEFT_W = $clog2(a85_pkg::NUM_DIGITS);
   localparam logic [LEFT_W-1:0] LEFT_ALL = LEFT_W'(a85_pkg::NUM_DIGITS - 1);

   typedef enum logic [5:0] {
      ST_DIGIT   = 6'b000001,
      ST_WRAP    = 6'b000010,
      ST_PRE_NL  = 6'b000100,
      ST_TILDE   = 6'b001000,
      ST_GT      = 6'b010000,
      ST_POST_NL = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic                busy_ff, busy_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   a85_pkg::digits_type dig_ff, dig_in;
   logic                zero_ff, zero_in;
   logic                lastjob_ff, lastjob_in;

   logic [COL_W:0]      col_inc;
   logic [COL_W-1:0]    col_next;
   logic [COL_W+1:0]    marker_end;
   logic                wrap;
   logic                near;
   logic                finish;
   logic                done;
   logic                step_digit;
   logic                emit;
   logic                take;
   logic [6:0]          ch;
   logic                last_flag;
   state_type           state_next;

   assign emit      = busy_ff && !out_full;
   assign take      = job_valid && (!busy_ff || (emit && done));
   assign job_ready = take;
   assign out_push  = emit;

   always_comb begin
      col_inc    = {1'b0, col_ff} + 1'b1;
      wrap       = (col_inc >= {1'b0, eff});
      ch         = a85_pkg::CH_NL;
      last_flag  = 1'b0;
      finish     = 1'b0;
      done       = 1'b0;
      step_digit = 1'b0;
      col_next   = col_ff;
      state_next = state_ff;
      unique case (state_ff)
         ST_DIGIT: begin
            ch = zero_ff ? a85_pkg::CH_Z
                         : dig_ff[a85_pkg::NUM_DIGITS-1] + a85_pkg::DIGIT_BASE;
            if (wrap) begin
               col_next   = '0;
               state_next = ST_WRAP;
            end else begin
               col_next = col_inc[COL_W-1:0];
               if (left_ff != '0) begin
                  step_digit = 1'b1;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         ST_WRAP: begin
            ch = a85_pkg::CH_NL;
            if (left_ff != '0) begin
               step_digit = 1'b1;
               state_next = ST_DIGIT;
            end else begin
               finish = 1'b1;
            end
         end
         ST_PRE_NL: begin
            ch         = a85_pkg::CH_NL;
            state_next = ST_TILDE;
         end
         ST_TILDE: begin
            ch         = a85_pkg::CH_TILDE;
            state_next = ST_GT;
         end
         ST_GT: begin
            ch         = a85_pkg::CH_GT;
            state_next = ST_POST_NL;
         end
         ST_POST_NL: begin
            ch        = a85_pkg::CH_NL;
            last_flag = 1'b1;
            done      = 1'b1;
            col_next  = '0;
         end
         default: begin
            state_next = ST_DIGIT;
         end
      endcase

      // The marker gets a line of its own when two more columns would overflow.
      marker_end = {2'b00, col_next} + 2'd2;
      near       = (marker_end > {2'b00, eff});
      if (finish) begin
         if (lastjob_ff && put_end_marker) begin
            state_next = near ? ST_PRE_NL : ST_TILDE;
         end else begin
            last_flag = 1'b1;
            done      = 1'b1;
            if (lastjob_ff) begin
               col_next = '0;
            end
         end
      end

      out_data.out_char  = ch;
      out_data.last_char = last_flag;
   end

   always_comb begin
      busy_in    = busy_ff;
      state_in   = state_ff;
      col_in     = emit ? col_next : col_ff;
      left_in    = left_ff;
      dig_in     = dig_ff;
      zero_in    = zero_ff;
      lastjob_in = lastjob_ff;
      if (take) begin
         busy_in    = 1'b1;
         state_in   = ST_DIGIT;
         left_in    = job.is_zero ? '0 : LEFT_ALL;
         dig_in     = job.digits;
         zero_in    = job.is_zero;
         lastjob_in = job.is_last;
      end else if (emit) begin
         state_in = state_next;
         if (done) begin
            busy_in = 1'b0;
         end
         if (step_digit) begin
            left_in = left_ff - 1'b1;
            dig_in  = {dig_ff[a85_pkg::NUM_DIGITS-2:0], 7'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         state_ff <= ST_DIGIT;
         col_ff   <= '0;
         left_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         state_ff <= state_in;
         col_ff   <= col_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff     <= dig_in;
      zero_ff    <= zero_in;
      lastjob_ff <= lastjob_in;
   end

endmodule

>>> sv/ascii85_line_wrapped_encoder.sv
`timescale 1ns / 1ps
// Line-wrapped ASCII85 encoder. A byte that completes a word (or ends a message) passes
// through the job queue, the base-85 converter, the emitter and the result queue. The
// converter takes the next word as it finishes the last, while the result side moves one
// character per cycle when the result queue has room. Reset (synchronous, active high)
// empties both queues, clears the word and column state and loads line width 75 with
// the end marker enabled; no clearing pass is needed.
module ascii85_line_wrapped_encoder #(
   parameter int MAX_LINE_WIDTH = a85_pkg::MAX_LINE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [6:0]                      rsp_out_char,
   output logic                            rsp_last_char,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [0:0]                      csr_index,
   input  logic [a85_pkg::LINE_WIDTH_W-1:0] csr_data
);

   localparam int CAP   = a85_pkg::eff_cap(MAX_LINE_WIDTH);
   localparam int COL_W = a85_pkg::col_bits(MAX_LINE_WIDTH);
   localparam int CAP_W = $clog2(CAP + 1);
   localparam int EW    = (CAP_W > 11) ? CAP_W : 11;
   localparam int JOB_W = $bits(a85_pkg::job_type);
   localparam int RSP_W = $bits(a85_pkg::rsp_type);

   logic [a85_pkg::LINE_WIDTH_W-1:0] lw_ff, lw_in;
   logic                             marker_ff, marker_in;
   logic [COL_W-1:0]                 eff_ff, eff_in;

   logic [a85_pkg::LINE_WIDTH_W-1:0] lw_m1;
   logic [17:0]                      prod;
   logic [7:0]                       quo_p1;
   logic [10:0]                      ceil5;
   logic [EW-1:0]                    eff_wide;

   logic                   q_push;
   logic                   q_full;
   logic                   q_empty;
   logic                   q_pop;
   a85_pkg::job_type       q_wr_job;
   a85_pkg::job_type       q_rd_job;
   logic                   res_valid;
   logic                   res_ready;
   a85_pkg::digit_job_type res_job;
   logic                   o_push;
   logic                   o_full;
   a85_pkg::rsp_type       o_wr;
   a85_pkg::rsp_type       o_rd;

   assign csr_ready = 1'b1;

   always_comb begin
      lw_in     = lw_ff;
      marker_in = marker_ff;
      if (csr_valid) begin
         unique case (a85_pkg::csr_index_type'(csr_index))
            a85_pkg::REG_LINE_WIDTH:     lw_in     = csr_data;
            a85_pkg::REG_PUT_END_MARKER: marker_in = csr_data[0];
         endcase
      end
   end

   // Round the width up to a multiple of five: (w - 1) / 5 + 1 by reciprocal, then times 5; 0 gives 5, capped at CAP.
   always_comb begin
      lw_m1  = lw_ff - 1'b1;
      prod   = 18'(lw_m1) * 18'(a85_pkg::RECIP5);
      quo_p1 = prod[17:10] + 8'd1;
      ceil5  = ({3'b000, quo_p1} << 2) + {3'b000, quo_p1};
      if (lw_ff == '0) begin
         eff_wide = EW'(a85_pkg::MIN_WIDTH);
      end else if (EW'(ceil5) > EW'(CAP)) begin
         eff_wide = EW'(CAP);
      end else begin
         eff_wide = EW'(ceil5);
      end
      eff_in = eff_wide[COL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff     <= a85_pkg::LINE_WIDTH_W'(a85_pkg::LINE_WIDTH_RESET);
         marker_ff <= 1'b1;
      end else begin
         lw_ff     <= lw_in;
         marker_ff <= marker_in;
      end
   end

   always_ff @(posedge clock) begin
      eff_ff <= eff_in;
   end

   a85_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_push        (q_push),
      .q_job         (q_wr_job),
      .q_full        (q_full)
   );

   a85_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (a85_pkg::JOB_DEPTH)
   ) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_job),
      .empty     (q_empty)
   );

   a85_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_job     (q_rd_job),
      .res_valid (res_valid),
      .res_job   (res_job),
      .res_ready (res_ready)
   );

   a85_emit #(
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
   ) u_emit (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (res_valid),
      .job            (res_job),
      .job_ready      (res_ready),
      .eff            (eff_ff),
      .put_end_marker (marker_ff),
      .out_push       (o_push),
      .out_data       (o_wr),
      .out_full       (o_full)
   );

   a85_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (a85_pkg::RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (o_push),
      .push_data (o_wr),
      .full      (o_full),
      .pop       (rsp_pop),
      .pop_data  (o_rd),
      .empty     (rsp_empty)
   );

   assign rsp_out_char  = o_rd.out_char;
   assign rsp_last_char = o_rd.last_char;

endmodule

>>> sv/a85_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the line-wrapped ASCII85 encoder, attached by bind.
// Depends on a85_pkg for character codes and on the top level's port list.
module a85_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [6:0] rsp_out_char,
   input logic       rsp_last_char
);

   // A waiting result holds until it is popped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> ($stable(rsp_out_char) && $stable(rsp_last_char)))
      else $error("result changed while waiting");

   // The result queue comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> rsp_empty)
      else $error("result queue not empty after reset");

   // Only digits, 'z', newline and the marker characters appear.
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_out_char >= a85_pkg::DIGIT_BASE && rsp_out_char <= 7'd117) ||
                      rsp_out_char == a85_pkg::CH_Z || rsp_out_char == a85_pkg::CH_NL ||
                      rsp_out_char == a85_pkg::CH_TILDE || rsp_out_char == a85_pkg::CH_GT))
      else $error("illegal output character");

   // The end marker is always followed by its newline, so it never closes a request.
   a_marker_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_out_char == a85_pkg::CH_TILDE || rsp_out_char == a85_pkg::CH_GT))
      |-> !rsp_last_char)
      else $error("marker character flagged as last");

endmodule

bind ascii85_line_wrapped_encoder a85_checker u_a85_checker (.*);

>>> verif/ascii85_line_wrapped_encoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the line-wrapped ASCII85 encoder: directed byte patterns,
// register settings and random messages, each checked against an encoder model kept here.
// Depends on a85_pkg and ascii85_line_wrapped_encoder.
module ascii85_line_wrapped_encoder_tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_PRINTS    = 60;
   localparam int IDLE_PERCENT  = 27;
   localparam int WIDTH_CAP     = (a85_pkg::MAX_LINE_WIDTH_DEF / 5) * 5;

   typedef struct {
      logic [6:0] ch;
      logic       last;
   } enc_char_type;

   logic                            clock;
   logic                            reset;
   logic                            req_push;
   logic                            req_full;
   logic [7:0]                      req_data_byte;
   logic                            req_last_byte;
   logic                            rsp_empty;
   logic                            rsp_pop;
   logic [6:0]                      rsp_out_char;
   logic                            rsp_last_char;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [0:0]                      csr_index;
   logic [a85_pkg::LINE_WIDTH_W-1:0] csr_data;

   // Register copies and encoder state as the block should hold them.
   logic [9:0]  line_width_reg;
   logic        end_marker_reg;
   logic [31:0] word_acc;
   logic [1:0]  word_fill;
   int unsigned line_col;

   enc_char_type expected_chars[$];
   int           mismatch_count;
   int           cycle_count;
   logic         idle_on;

   ascii85_line_wrapped_encoder uut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #1 clock = ~clock;

   function automatic int unsigned wrap_width();
      int unsigned w;
      if (line_width_reg == 0) w = 5;
      else w = ((int'(line_width_reg) - 1) / 5 + 1) * 5;
      if (w > WIDTH_CAP) w = WIDTH_CAP;
      return w;
   endfunction

   // Works out the characters that one accepted byte causes and queues them.
   function automatic void encode_byte(logic [7:0] b, logic last);
      logic [6:0]  text[$];
      logic [6:0]  outq[$];
      logic [31:0] w;
      logic [31:0] rem;
      logic [31:0] weight;
      int unsigned fill;
      int unsigned eff;
      eff = wrap_width();
      word_acc = {word_acc[23:0], b};
      fill = word_fill + 1;
      if (fill == 4 || last) begin
         w = word_acc << (8 * (4 - fill));
         if (w == 0) begin
            text.push_back(a85_pkg::CH_Z);
         end else begin
            rem = w;
            weight = 32'd52200625;
            for (int i = 0; i < 5; i++) begin
               text.push_back(7'(32'd33 + rem / weight));
               rem = rem % weight;
               weight = weight / 85;
            end
         end
         word_acc = '0;
         word_fill = '0;
      end else begin
         word_fill = fill[1:0];
      end
      foreach (text[i]) begin
         outq.push_back(text[i]);
         line_col++;
         if (line_col >= eff) begin
            outq.push_back(a85_pkg::CH_NL);
            line_col = 0;
         end
      end
      if (last) begin
         if (end_marker_reg) begin
            if (line_col + 2 > eff) outq.push_back(a85_pkg::CH_NL);
            outq.push_back(a85_pkg::CH_TILDE);
            outq.push_back(a85_pkg::CH_GT);
            outq.push_back(a85_pkg::CH_NL);
         end
         word_acc = '0;
         word_fill = '0;
         line_col = 0;
      end
      foreach (outq[i])
         expected_chars.push_back('{ch: outq[i], last: (i == outq.size() - 1)});
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
   endtask

   // Sends one byte; called at a falling edge, returns at the falling edge after acceptance
   // with push still high so that back-to-back requests need no gap.
   task automatic send_byte(logic [7:0] b, logic last);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push = 1'b1;
      req_data_byte = b;
      req_last_byte = last;
      do @(posedge clock); while (req_full);
      encode_byte(b, last);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_push = 1'b0;
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register writes happen only once the block has gone quiet.
   task automatic write_csr(a85_pkg::csr_index_type idx, logic [9:0] val);
      wait_idle();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         a85_pkg::REG_LINE_WIDTH:     line_width_reg = val;
         a85_pkg::REG_PUT_END_MARKER: end_marker_reg = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Words are drawn whole: zero, all ones, sparse or random, so that 'z' shows up often; dense: no zero bytes.
   task automatic send_random_message(int len, logic dense);
      int         mode;
      logic [7:0] b;
      mode = 0;
      for (int i = 0; i < len; i++) begin
         if (i % 4 == 0) mode = $urandom_range(99);
         if (dense) b = 8'($urandom_range(1, 255));
         else if (mode < 20) b = 8'h00;
         else if (mode < 30) b = 8'hFF;
         else if (mode < 45) b = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
         else b = 8'($urandom_range(255));
         send_byte(b, i == len - 1);
      end
   endtask

   task automatic test_word_values();
      repeat (4) send_byte(8'h00, 1'b0);
      repeat (4) send_byte(8'hFF, 1'b0);
      send_byte(8'hAB, 1'b0);
      send_byte(8'hCD, 1'b0);
      send_byte(8'hEF, 1'b1);
      // A lone zero byte pads to a zero word.
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_end_marker();
      write_csr(a85_pkg::REG_LINE_WIDTH, 10'd5);
      // Four 'z' leave column 4 of 5, so the marker must start on a new line.
      repeat (12) send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      write_csr(a85_pkg::REG_PUT_END_MARKER, 10'd0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hC3, 1'b1);
      write_csr(a85_pkg::REG_PUT_END_MARKER, 10'd1);
   endtask

   task automatic test_width_change_midline();
      write_csr(a85_pkg::REG_LINE_WIDTH, 10'd75);
      send_random_message(4, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h17, 1'b0);
      send_byte(8'h99, 1'b0);
      send_byte(8'h01, 1'b0);
      // The column count now sits at the new, narrower width.
      write_csr(a85_pkg::REG_LINE_WIDTH, 10'd1);
      send_byte(8'h7E, 1'b1);
   endtask

   task automatic test_width_extremes();
      write_csr(a85_pkg::REG_LINE_WIDTH, 10'd0);
      send_random_message(9, 1'b0);
      // A width above the cap rounds past it and is clamped.
      write_csr(a85_pkg::REG_LINE_WIDTH, 10'd1023);
      send_random_message(12, 1'b1);
      write_csr(a85_pkg::REG_LINE_WIDTH, 10'd1020);
      send_random_message(6, 1'b0);
      write_csr(a85_pkg::REG_LINE_WIDTH, 10'd6);
      send_random_message(7, 1'b0);
   endtask

   task automatic test_random_messages(int byte_budget);
      int sent;
      int phase;
      int len;
      int pick;
      int msgs;
      sent = 0;
      phase = 0;
      while (sent < byte_budget) begin
         pick = $urandom_range(99);
         if (pick < 60) write_csr(a85_pkg::REG_LINE_WIDTH, 10'($urandom_range(0, 12)));
         else if (pick < 85) write_csr(a85_pkg::REG_LINE_WIDTH, 10'($urandom_range(13, 80)));
         else write_csr(a85_pkg::REG_LINE_WIDTH, 10'($urandom_range(0, 1023)));
         write_csr(a85_pkg::REG_PUT_END_MARKER, 10'($urandom_range(1)));
         // The first phase runs flat out on both sides.
         idle_on = (phase != 0);
         msgs = (phase == 0) ? 10 : $urandom_range(2, 5);
         repeat (msgs) begin
            len = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            send_random_message(len, 1'b0);
            sent += len;
         end
         phase++;
      end
      idle_on = 1'b1;
   endtask

   always @(negedge clock) begin
      if (idle_on) rsp_pop <= ($urandom_range(99) >= IDLE_PERCENT);
      else rsp_pop <= 1'b1;
   end

   always @(posedge clock) begin : check_chars
      enc_char_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_chars.size() == 0) begin
            report_mismatch("unexpected character", rsp_out_char, -1);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_out_char !== want.ch) report_mismatch("out_char", rsp_out_char, want.ch);
            if (rsp_last_char !== want.last)
               report_mismatch("last_char", rsp_last_char, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ascii85_line_wrapped_encoder_tb: errors");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_push = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      rsp_pop = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_on = 1'b1;
      line_width_reg = 10'(a85_pkg::LINE_WIDTH_RESET);
      end_marker_reg = 1'b1;
      word_acc = '0;
      word_fill = '0;
      line_col = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_word_values();
      test_end_marker();
      test_width_change_midline();
      test_width_extremes();
      test_random_messages(170);

      wait_idle();
      if (mismatch_count == 0) $display("ascii85_line_wrapped_encoder_tb: clean");
      else $display("ascii85_line_wrapped_encoder_tb: errors");
      $finish;
   end

endmodule

>>> filelist.f
sv/a85_pkg.sv
sv/a85_fifo.sv
sv/a85_front.sv
sv/a85_conv.sv
sv/a85_emit.sv
sv/ascii85_line_wrapped_encoder.sv
sv/a85_checker.sv
verif/ascii85_line_wrapped_encoder_tb.sv
